[hw/rtl/iett_pkg.sv]
// ----------------------------------------------------------------------------
// iett_pkg
// Shared types and constants of the interrupt elapsed-time tracker: payload
// structs, register indexes, timing constants and divider request/response.
// ----------------------------------------------------------------------------
`default_nettype none

package iett_pkg;

    // lower clamp of the microsecond period is resolution * (1 + delta)
    localparam int unsigned COUNTER_DELTA = 1;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_UNITS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RESOLUTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PERIOD   = 2'd2;

    // item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // time constants
    localparam logic [15:0] US_PER_MS      = 16'd1000;
    localparam logic [11:0] MAX_PERIOD_US  = 12'd1300;
    localparam logic [15:0] MIN_PERIOD_MS  = 16'd1;
    localparam logic [15:0] MAX_PERIOD_MS  = 16'd49;
    localparam logic [11:0] RES_FINE_US    = 12'd20;
    localparam logic [11:0] RES_COARSE_US  = 12'd100;
    localparam logic [11:0] LO_FINE_US     = 12'(20 * (1 + COUNTER_DELTA));
    localparam logic [11:0] LO_COARSE_US   = 12'(100 * (1 + COUNTER_DELTA));
    // any target above this rounds to at least 2000 and clamps to the maximum
    localparam logic [15:0] TARGET_SAT     = 16'd2047;

    // reset value of microseconds per tick
    localparam logic [19:0] US_PER_TICK_RST = 20'd1000;

    // serial divider
    localparam int unsigned DIVIDEND_W = 21;
    localparam int unsigned DIVISOR_W  = 16;
    localparam int unsigned DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIVIDEND_W);

    typedef struct packed {
        logic        opcode;
        logic [19:0] frame_elapsed_us;
    } t_in;

    typedef struct packed {
        logic [31:0] frame_ms;
        logic [31:0] total_ms;
        logic [15:0] interrupts_in_frame;
        logic [19:0] us_per_interrupt;
    } t_out;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

[hw/rtl/iett_period.sv]
// ----------------------------------------------------------------------------
// iett_period
// Effective tick period in microseconds from the unit, resolution and target
// registers: rounding to the resolution and clamping to the allowed range.
// ----------------------------------------------------------------------------
`default_nettype none

module iett_period (
    input  wire logic        i_time_units,
    input  wire logic        i_tick_resolution,
    input  wire logic [15:0] i_target_period,
    output logic      [19:0] o_period_us
);

    logic [10:0] t11;
    logic [22:0] prod_f;
    logic [21:0] prod_c;
    logic [6:0]  q_f;
    logic [4:0]  q_c;
    logic [11:0] rnd_f;
    logic [11:0] rnd_c;
    logic [11:0] res_us;
    logic [11:0] lo_us;
    logic [11:0] rnd;
    logic [11:0] us_val;
    logic [5:0]  ms_val;
    logic [15:0] ms_us;

    assign t11 = i_target_period[10:0];

    // quotient by 20 and by 100 through reciprocal multiply, exact below 2048
    assign prod_f = {12'b0, t11} * 23'd3277;
    assign prod_c = {11'b0, t11} * 22'd1311;
    assign q_f    = prod_f[22:16];
    assign q_c    = prod_c[21:17];

    // round down to the resolution with shift-add products
    assign rnd_f = {1'b0, q_f, 4'b0} + {3'b0, q_f, 2'b0};
    assign rnd_c = {1'b0, q_c, 6'b0} + {2'b0, q_c, 5'b0} + {5'b0, q_c, 2'b0};

    assign res_us = i_tick_resolution ? iett_pkg::RES_COARSE_US : iett_pkg::RES_FINE_US;
    assign lo_us  = i_tick_resolution ? iett_pkg::LO_COARSE_US : iett_pkg::LO_FINE_US;

    // microsecond mode: round only when the target reaches the resolution, then clamp
    always_comb begin
        if ({1'b0, t11} >= res_us) begin
            rnd = i_tick_resolution ? rnd_c : rnd_f;
        end else begin
            rnd = {1'b0, t11};
        end
        if (i_target_period > iett_pkg::TARGET_SAT) begin
            us_val = iett_pkg::MAX_PERIOD_US;
        end else if (rnd < lo_us) begin
            us_val = lo_us;
        end else if (rnd > iett_pkg::MAX_PERIOD_US) begin
            us_val = iett_pkg::MAX_PERIOD_US;
        end else begin
            us_val = rnd;
        end
    end

    // millisecond mode: clamp then scale
    always_comb begin
        if (i_target_period < iett_pkg::MIN_PERIOD_MS) begin
            ms_val = iett_pkg::MIN_PERIOD_MS[5:0];
        end else if (i_target_period > iett_pkg::MAX_PERIOD_MS) begin
            ms_val = iett_pkg::MAX_PERIOD_MS[5:0];
        end else begin
            ms_val = i_target_period[5:0];
        end
    end

    assign ms_us = {10'b0, ms_val} * iett_pkg::US_PER_MS;

    assign o_period_us = i_time_units ? {4'b0, ms_us} : {8'b0, us_val};

endmodule

`default_nettype wire

[hw/rtl/iett_divider.sv]
// ----------------------------------------------------------------------------
// iett_divider
// Shared restoring divider, one quotient bit per cycle, used both for the
// millisecond carry and for the per-frame recalibration.
// ----------------------------------------------------------------------------
`default_nettype none

module iett_divider (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire iett_pkg::t_div_req i_req,
    output iett_pkg::t_div_rsp      o_rsp
);

    logic                                r_busy;
    logic                                r_done;
    logic [iett_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [iett_pkg::DIVIDEND_W-1:0]     r_quo;
    logic [iett_pkg::DIVISOR_W-1:0]      r_rem;
    logic [iett_pkg::DIVISOR_W-1:0]      r_dvs;

    logic [iett_pkg::DIVISOR_W:0]        shifted;
    logic [iett_pkg::DIVISOR_W:0]        diff;
    logic                                fits;
    logic [iett_pkg::DIVIDEND_W-1:0]     n_quo;
    logic [iett_pkg::DIVISOR_W-1:0]      n_rem;

    // one trial subtraction per step
    assign shifted = {r_rem, r_quo[iett_pkg::DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, r_dvs};
    assign fits    = shifted >= {1'b0, r_dvs};
    assign n_rem   = fits ? diff[iett_pkg::DIVISOR_W-1:0] : shifted[iett_pkg::DIVISOR_W-1:0];
    assign n_quo   = {r_quo[iett_pkg::DIVIDEND_W-2:0], fits};

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= iett_pkg::DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == iett_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

[hw/rtl/interrupt_elapsed_time_tracker_top.sv]
// ----------------------------------------------------------------------------
// interrupt_elapsed_time_tracker_top
// Elapsed-time tracker driven by timer tick and frame-start items, with a
// small sequencer around one shared serial divider.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_in_data        | item in
//  out     | o_out_valid, i_out_stall, o_out_data     | result out
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data          | register write
//
//  A tick that carries no millisecond and a frame start with no counted ticks
//  show a valid result in the cycle after the transfer; all other items run
//  the divider for 21 steps before the result is registered.
//  One item at a time: input stalls from transfer until the result is taken.
//  Synchronous active-low reset; counters clear, us per tick goes to 1000.
//  A stalled result holds in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_elapsed_time_tracker_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire iett_pkg::t_in                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output iett_pkg::t_out                         o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [iett_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [iett_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic                 r_op, n_op;
    logic                 r_units, n_units;
    logic                 r_res, n_res;
    logic [15:0]          r_target, n_target;
    logic [20:0]          r_rem, n_rem;
    logic [31:0]          r_frame, n_frame;
    logic [31:0]          r_total, n_total;
    logic [15:0]          r_tick, n_tick;
    logic [19:0]          r_upt, n_upt;
    iett_pkg::t_out       r_out, n_out;

    logic                 cfg_hit;
    logic                 load_out;
    logic [21:0]          sum_wide;
    logic [20:0]          sum;
    logic [19:0]          eff_us;
    iett_pkg::t_div_req   div_req;
    iett_pkg::t_div_rsp   div_rsp;

    // effective period from the register values after any write this cycle
    iett_period u_period (
        .i_time_units      (n_units),
        .i_tick_resolution (n_res),
        .i_target_period   (n_target),
        .o_period_us       (eff_us)
    );

    iett_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign sum_wide = {1'b0, r_rem} + {2'b0, r_upt};
    assign sum      = sum_wide[20:0];

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_units  = r_units;
        n_res    = r_res;
        n_target = r_target;
        n_rem    = r_rem;
        n_frame  = r_frame;
        n_total  = r_total;
        n_tick   = r_tick;
        n_upt    = r_upt;
        load_out = 1'b0;
        cfg_hit  = 1'b0;
        div_req  = '0;

        // register writes reload us per tick
        if (i_cfg_we) begin
            case (i_cfg_idx)
                iett_pkg::CFG_TIME_UNITS: begin
                    n_units = i_cfg_data[0];
                    cfg_hit = 1'b1;
                end
                iett_pkg::CFG_TICK_RESOLUTION: begin
                    n_res   = i_cfg_data[0];
                    cfg_hit = 1'b1;
                end
                iett_pkg::CFG_TARGET_PERIOD: begin
                    n_target = i_cfg_data;
                    cfg_hit  = 1'b1;
                end
                default: ;
            endcase
        end
        if (cfg_hit) begin
            n_upt = eff_us;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_in_data.opcode;
                    if (i_in_data.opcode == iett_pkg::OP_TICK) begin
                        // tick: count and accumulate
                        if (r_tick != 16'hFFFF) begin
                            n_tick = r_tick + 16'd1;
                        end
                        if (sum > {5'b0, iett_pkg::US_PER_MS}) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = sum;
                            div_req.divisor  = iett_pkg::US_PER_MS;
                            n_state          = ST_DIV;
                        end else begin
                            n_rem    = sum;
                            load_out = 1'b1;
                            n_state  = ST_OUT;
                        end
                    end else begin
                        // frame start: clear and recalibrate
                        n_frame = '0;
                        n_rem   = '0;
                        n_tick  = '0;
                        if (r_tick == 16'd0) begin
                            n_upt    = eff_us;
                            load_out = 1'b1;
                            n_state  = ST_OUT;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = {1'b0, i_in_data.frame_elapsed_us};
                            div_req.divisor  = r_tick;
                            n_state          = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (r_op == iett_pkg::OP_TICK) begin
                        n_frame = r_frame + {11'b0, div_rsp.quotient};
                        n_total = r_total + {11'b0, div_rsp.quotient};
                        n_rem   = {5'b0, div_rsp.remainder};
                    end else begin
                        n_upt = div_rsp.quotient[19:0];
                    end
                    load_out = 1'b1;
                    n_state  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // result shows the state after the item
        if (load_out) begin
            n_out.frame_ms            = n_frame;
            n_out.total_ms            = n_total;
            n_out.interrupts_in_frame = n_tick;
            n_out.us_per_interrupt    = n_upt;
        end else begin
            n_out = r_out;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_units  <= 1'b1;
            r_res    <= 1'b1;
            r_target <= 16'd1;
            r_rem    <= '0;
            r_frame  <= '0;
            r_total  <= '0;
            r_tick   <= '0;
            r_upt    <= iett_pkg::US_PER_TICK_RST;
        end else begin
            r_state  <= n_state;
            r_units  <= n_units;
            r_res    <= n_res;
            r_target <= n_target;
            r_rem    <= n_rem;
            r_frame  <= n_frame;
            r_total  <= n_total;
            r_tick   <= n_tick;
            r_upt    <= n_upt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[hw/rtl/iett_checker.sv]
// ----------------------------------------------------------------------------
// iett_checker
// Port-level checks of the tracker: one item in flight, result hold and
// release, and a bind onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iett_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              o_in_stall,
    input  wire logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    input  wire iett_pkg::t_out                    o_out_data
);

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    // stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // after an input transfer the block is busy
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input accepted while an item is in flight");

    // a pending result blocks new items
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result waits");

    // a taken result is not repeated
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |=> !o_out_valid)
        else $error("result repeated after transfer");

endmodule

bind interrupt_elapsed_time_tracker_top iett_checker u_iett_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

[tb/interrupt_elapsed_time_tracker_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interrupt_elapsed_time_tracker_checker
// Watches the item, result and register channels of the elapsed-time
// tracker. It keeps its own copy of the registers and counters, works out the
// expected result of every item transfer and compares each result transfer,
// field by field, against the oldest expected result.
// ----------------------------------------------------------------------------
module interrupt_elapsed_time_tracker_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire iett_pkg::t_in                     i_in_data,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire iett_pkg::t_out                    i_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [iett_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [iett_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    // register copy
    logic        cfg_ms_units;
    logic        cfg_coarse_res;
    logic [15:0] cfg_target;

    // counter copy
    logic [20:0] acc_us;
    logic [31:0] frame_ms_cnt;
    logic [31:0] total_ms_cnt;
    logic [15:0] irq_cnt;
    logic [19:0] tick_us;

    iett_pkg::t_out expected_times[$];
    int             mismatches = 0;

    // period in us derived from the registers
    function automatic logic [19:0] period_us();
        int unsigned t;
        int unsigned res;
        int unsigned lo;
        int unsigned rem;
        t = cfg_target;
        if (cfg_ms_units) begin
            if (t < iett_pkg::MIN_PERIOD_MS)
                t = iett_pkg::MIN_PERIOD_MS;
            else if (t > iett_pkg::MAX_PERIOD_MS)
                t = iett_pkg::MAX_PERIOD_MS;
            return 20'(t * iett_pkg::US_PER_MS);
        end
        res = cfg_coarse_res ? iett_pkg::RES_COARSE_US : iett_pkg::RES_FINE_US;
        lo  = res * (1 + iett_pkg::COUNTER_DELTA);
        rem = t % res;
        // round down only once the target reaches the resolution
        if (t > rem)
            t = t - rem;
        if (t < lo)
            t = lo;
        else if (t > iett_pkg::MAX_PERIOD_US)
            t = iett_pkg::MAX_PERIOD_US;
        return 20'(t);
    endfunction

    // register write, unknown index leaves everything alone
    task automatic apply_write(input logic [iett_pkg::CFG_IDX_W-1:0] idx,
                               input logic [iett_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            iett_pkg::CFG_TIME_UNITS: begin
                cfg_ms_units = data[0];
            end
            iett_pkg::CFG_TICK_RESOLUTION: begin
                cfg_coarse_res = data[0];
            end
            iett_pkg::CFG_TARGET_PERIOD: begin
                cfg_target = data;
            end
            default: begin
                return;
            end
        endcase
        tick_us = period_us();
    endtask

    // advance the counters by one item and return what the block shows
    function automatic iett_pkg::t_out advance_tracker(input iett_pkg::t_in item);
        iett_pkg::t_out shown;
        logic [31:0]    carry_ms;
        if (item.opcode == iett_pkg::OP_TICK) begin
            if (irq_cnt != 16'hFFFF)
                irq_cnt = irq_cnt + 16'd1;
            acc_us = acc_us + tick_us;
            // carry only above a full millisecond, exactly 1000 stays
            if (acc_us > iett_pkg::US_PER_MS) begin
                carry_ms     = acc_us / iett_pkg::US_PER_MS;
                acc_us       = 21'(acc_us % iett_pkg::US_PER_MS);
                frame_ms_cnt = frame_ms_cnt + carry_ms;
                total_ms_cnt = total_ms_cnt + carry_ms;
            end
        end else begin
            frame_ms_cnt = '0;
            acc_us       = '0;
            // recalibrate from the measured frame, or fall back to the period
            if (irq_cnt == 16'd0)
                tick_us = period_us();
            else
                tick_us = 20'(item.frame_elapsed_us / irq_cnt);
            irq_cnt = '0;
        end
        shown.frame_ms            = frame_ms_cnt;
        shown.total_ms            = total_ms_cnt;
        shown.interrupts_in_frame = irq_cnt;
        shown.us_per_interrupt    = tick_us;
        return shown;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name,
                         want, got);
            mismatches++;
        end
    endtask

    // channel monitor
    always @(posedge i_clk) begin
        iett_pkg::t_out want;
        if (!i_rst_n) begin
            cfg_ms_units   = 1'b1;
            cfg_coarse_res = 1'b1;
            cfg_target     = 16'd1;
            acc_us         = '0;
            frame_ms_cnt   = '0;
            total_ms_cnt   = '0;
            irq_cnt        = '0;
            tick_us        = iett_pkg::US_PER_TICK_RST;
            expected_times.delete();
        end else begin
            if (i_cfg_we)
                apply_write(i_cfg_idx, i_cfg_data);
            if (i_in_valid && !i_in_stall)
                expected_times.push_back(advance_tracker(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_times.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result transfer with none expected", $realtime);
                    mismatches++;
                end else begin
                    want = expected_times.pop_front();
                    check_field("frame_ms", want.frame_ms, i_out_data.frame_ms);
                    check_field("total_ms", want.total_ms, i_out_data.total_ms);
                    check_field("interrupts_in_frame", 32'(want.interrupts_in_frame),
                                32'(i_out_data.interrupts_in_frame));
                    check_field("us_per_interrupt", 32'(want.us_per_interrupt),
                                32'(i_out_data.us_per_interrupt));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_times.size();
    end

endmodule

[tb/interrupt_elapsed_time_tracker_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interrupt_elapsed_time_tracker_top_tb
// Drives tick and frame-start items and register writes into the elapsed-time
// tracker: a directed opening, random phases over many register settings,
// and a calm tick run with nothing credited per tick. Both channels idle at
// random unless calm; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module interrupt_elapsed_time_tracker_top_tb;

    localparam logic [iett_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam int unsigned IDLE_PCT      = 29;
    localparam int unsigned PHASES        = 10;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned HOLD_AFTER    = 300;
    localparam int unsigned HOLD_CYCLES   = 150;
    localparam int unsigned SETTLE_CYCLES = 30;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned TAIL_TICKS    = 40;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_stall;
    iett_pkg::t_in                   i_in_data   = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    iett_pkg::t_out                  o_out_data;
    logic                            i_cfg_we    = 1'b0;
    logic [iett_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [iett_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic        calm          = 1'b0;
    logic        hold_armed    = 1'b1;
    int unsigned hold_left     = 0;
    int unsigned results_taken = 0;
    int unsigned quiet_cycles  = 0;
    int          fail_count;
    int          pending;

    interrupt_elapsed_time_tracker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    interrupt_elapsed_time_tracker_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            results_taken <= results_taken + 1;
    end

    // result side: random stalls, one long hold-off, none while calm
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_armed && results_taken >= HOLD_AFTER) begin
            hold_armed  <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("interrupt_elapsed_time_tracker_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic iett_pkg::t_in mk_item(input logic op, input logic [19:0] us);
        iett_pkg::t_in item;
        item.opcode           = op;
        item.frame_elapsed_us = us;
        return item;
    endfunction

    // mostly ticks, elapsed time spread over edges and the full range
    function automatic iett_pkg::t_in rand_item();
        iett_pkg::t_in item;
        item.opcode = ($urandom_range(99) < 12) ? iett_pkg::OP_FRAME : iett_pkg::OP_TICK;
        case ($urandom_range(3))
            0:       item.frame_elapsed_us = '0;
            1:       item.frame_elapsed_us = '1;
            2:       item.frame_elapsed_us = 20'($urandom());
            default: item.frame_elapsed_us = 20'($urandom_range(3000));
        endcase
        return item;
    endfunction

    // targets around the rounding and clamp edges of both unit modes
    function automatic logic [15:0] pick_target();
        case ($urandom_range(31))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd5;
            3:       return 16'd19;
            4:       return 16'd20;
            5:       return 16'd21;
            6:       return 16'd39;
            7:       return 16'd40;
            8:       return 16'd41;
            9:       return 16'd49;
            10:      return 16'd50;
            11:      return 16'd99;
            12:      return 16'd100;
            13:      return 16'd199;
            14:      return 16'd200;
            15:      return 16'd201;
            16:      return 16'd250;
            17:      return 16'd1299;
            18:      return 16'd1300;
            19:      return 16'd1301;
            20:      return 16'd2047;
            21:      return 16'd2048;
            22:      return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // one item transfer, with random idle cycles ahead of it unless calm
    task automatic send_item(input iett_pkg::t_in item);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop offering and wait until every result is back and the block is idle
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [iett_pkg::CFG_IDX_W-1:0] idx,
                             input logic [iett_pkg::CFG_DATA_W-1:0] data);
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // stimulus
    initial begin
        int unsigned p;
        int unsigned n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting gives 1000 us per tick: exactly 1000 is kept, 2000 carries
        send_item(mk_item(iett_pkg::OP_TICK, '0));
        send_item(mk_item(iett_pkg::OP_TICK, '1));
        send_item(mk_item(iett_pkg::OP_FRAME, '1));
        // frame start without ticks falls back to the period
        send_item(mk_item(iett_pkg::OP_FRAME, '0));
        send_item(mk_item(iett_pkg::OP_TICK, '0));
        send_item(mk_item(iett_pkg::OP_FRAME, '0));
        send_item(mk_item(iett_pkg::OP_TICK, 20'h5A5A5));

        // us units with bits above the register width set, then extreme targets
        write_reg(iett_pkg::CFG_TIME_UNITS, 16'hFFFE);
        write_reg(iett_pkg::CFG_TICK_RESOLUTION, 16'h0002);
        write_reg(iett_pkg::CFG_TARGET_PERIOD, 16'hFFFF);
        send_item(mk_item(iett_pkg::OP_TICK, '0));
        send_item(mk_item(iett_pkg::OP_TICK, '0));
        // unknown index must not reload the period
        write_reg(CFG_SPARE_IDX, 16'h0000);
        send_item(mk_item(iett_pkg::OP_TICK, '0));
        write_reg(iett_pkg::CFG_TARGET_PERIOD, 16'h0000);
        send_item(mk_item(iett_pkg::OP_FRAME, '0));
        send_item(mk_item(iett_pkg::OP_FRAME, 20'd12345));
        send_item(mk_item(iett_pkg::OP_TICK, '0));

        // ms units, clamp at both ends
        write_reg(iett_pkg::CFG_TIME_UNITS, 16'h0001);
        send_item(mk_item(iett_pkg::OP_TICK, '0));
        write_reg(iett_pkg::CFG_TARGET_PERIOD, 16'hFFFF);
        send_item(mk_item(iett_pkg::OP_TICK, '0));
        send_item(mk_item(iett_pkg::OP_FRAME, 20'd1000000));
        send_item(mk_item(iett_pkg::OP_TICK, '0));

        // coarse resolution, target between multiples
        write_reg(iett_pkg::CFG_TICK_RESOLUTION, 16'hFFFF);
        write_reg(iett_pkg::CFG_TIME_UNITS, 16'h0000);
        write_reg(iett_pkg::CFG_TARGET_PERIOD, 16'd250);
        send_item(mk_item(iett_pkg::OP_TICK, '0));
        send_item(mk_item(iett_pkg::OP_FRAME, '1));
        send_item(mk_item(iett_pkg::OP_TICK, '0));
        send_item(mk_item(iett_pkg::OP_TICK, '0));

        // random phases, each under its own register setting
        for (p = 0; p < PHASES; p++) begin
            calm <= (p == 4);
            write_reg(iett_pkg::CFG_TIME_UNITS, 16'(($urandom() & 32'hFFFE) | (p & 1)));
            write_reg(iett_pkg::CFG_TICK_RESOLUTION,
                      16'(($urandom() & 32'hFFFE) | ((p >> 1) & 1)));
            write_reg(iett_pkg::CFG_TARGET_PERIOD, pick_target());
            if ($urandom_range(3) == 0)
                write_reg(CFG_SPARE_IDX, 16'($urandom()));
            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_item());
        end

        // zero us per tick, then a calm run of ticks that credit nothing
        wait_quiet();
        calm <= 1'b1;
        send_item(mk_item(iett_pkg::OP_TICK, '0));
        send_item(mk_item(iett_pkg::OP_FRAME, '0));
        for (n = 0; n < TAIL_TICKS; n++)
            send_item(mk_item(iett_pkg::OP_TICK, 20'($urandom())));
        send_item(mk_item(iett_pkg::OP_FRAME, '1));
        send_item(mk_item(iett_pkg::OP_TICK, '0));

        wait_quiet();
        if (fail_count == 0 && pending == 0)
            $display("interrupt_elapsed_time_tracker_top regression: pass");
        else
            $display("interrupt_elapsed_time_tracker_top regression: fail");
        $finish;
    end

endmodule
